// ===== rtl/core/ihra_pkg.sv =====
package ihra_pkg;

    // Sizes of the count tables.
    localparam int WIDE_BINS   = 65536;
    localparam int NARROW_BINS = 256;
    localparam int COUNT_W     = 24;

    localparam int WIDE_AW   = $clog2(WIDE_BINS);
    localparam int NARROW_AW = $clog2(NARROW_BINS);

    // Field widths of the command and result items.
    localparam int KIND_W      = 2;
    localparam int MODE_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int CHANNEL_W   = 8;
    localparam int BIN_NUM_W   = 16;
    localparam int BIN_COUNT_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Sum of three counts and its division by three through a reciprocal.
    // With DIV_SHIFT two bits above the sum width the rounded-up reciprocal
    // gives the exact floor for every sum.
    localparam int SUM_W     = COUNT_W + 2;
    localparam int DIV_SHIFT = SUM_W + 2;
    localparam int DIV_MUL_W = SUM_W + 1;
    localparam longint unsigned DIV_MUL_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_FULL);
    localparam int PROD_W    = SUM_W + DIV_MUL_W;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Mode codes; bit 1 set selects the colour tables.
    localparam logic [MODE_W-1:0] MODE_GREY8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREY16 = 2'd1;
    localparam int                MODE_RGB_BIT = 1;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SAMPLE_W-1:0]  gray;
        logic [CHANNEL_W-1:0] red;
        logic [CHANNEL_W-1:0] green;
        logic [CHANNEL_W-1:0] blue;
        logic [SAMPLE_W-1:0]  bin_index;
    } cmd_t;

    typedef struct packed {
        logic [BIN_NUM_W-1:0]   bin_number;
        logic [BIN_COUNT_W-1:0] bin_count;
    } result_t;

    // Control handed from the sequencer to the merging stage with each read.
    typedef struct packed {
        logic                 valid;
        logic                 rgb;
        logic                 in_range;
        logic [BIN_NUM_W-1:0] bin_number;
    } merge_ctrl_t;

endpackage

// ===== rtl/core/ihra_ram.sv =====
module ihra_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ihra_merge.sv =====
module ihra_merge
    import ihra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  merge_ctrl_t        ctrl,
    input  logic [COUNT_W-1:0] red_count,
    input  logic [COUNT_W-1:0] green_count,
    input  logic [COUNT_W-1:0] blue_count,
    output logic               done,
    output result_t            result
);

    logic                 s1_valid_reg;
    logic                 s1_rgb_reg;
    logic [BIN_NUM_W-1:0] s1_bin_reg;
    logic [SUM_W-1:0]     s1_sum_reg;
    logic [SUM_W-1:0]     s1_sum_next;

    logic [PROD_W-1:0]    prod;
    logic [COUNT_W-1:0]   quot;

    logic                 done_reg;
    result_t              result_reg;

    // First stage: add the three lanes, or pass the single grey lane, or zero when out of range.
    always_comb
    begin
        if (ctrl.rgb)
        begin
            s1_sum_next = SUM_W'(red_count) + SUM_W'(green_count) + SUM_W'(blue_count);
        end
        else if (ctrl.in_range)
        begin
            s1_sum_next = SUM_W'(red_count);
        end
        else
        begin
            s1_sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.valid;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            s1_rgb_reg <= ctrl.rgb;
            s1_bin_reg <= ctrl.bin_number;
            s1_sum_reg <= s1_sum_next;
        end
        if (s1_valid_reg)
        begin
            result_reg.bin_number <= s1_bin_reg;
            result_reg.bin_count  <= BIN_COUNT_W'(quot);
        end
    end

    // Second stage: divide by three through the reciprocal in colour mode.
    assign prod = PROD_W'(s1_sum_reg) * PROD_W'(DIV_MUL);
    assign quot = s1_rgb_reg ? COUNT_W'(prod >> DIV_SHIFT) : COUNT_W'(s1_sum_reg);

    assign done   = done_reg;
    assign result = result_reg;

    // A result leaves only after a read went through the adding stage.
    a_done_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(s1_valid_reg))
        else $error("merge result without a summed read");

endmodule

// ===== rtl/core/image_histogram_rgb_average.sv =====
// Image histogram with three count tables working as parallel lanes. An item is
// taken on start while busy is low. Accumulate and read items read the tables
// on the accepting edge, and an accumulate writes them back, saturating, in the
// next cycle; this read-modify-write through a single write port per table
// keeps busy high until the write-back, so no new item is taken before it. A
// read's counts pass through the sum and result registers of the merge stage;
// done is then raised for a single cycle; the receiver cannot stall the result,
// so it must take it then. A clear item, and reset, start a sweep that zeroes
// all three tables one address per cycle over all WIDE_BINS addresses (65536),
// during which busy stays high; mode may still be written. Mode is written
// through mode_we and mode_wdata and should only change while the block is
// idle. A colour read gives the floor of the red, green and blue sum over three.
module image_histogram_rgb_average
    import ihra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmd_t              cmd,
    output logic              busy,
    output logic              done,
    output result_t           result,
    input  logic              mode_we,
    input  logic [MODE_W-1:0] mode_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_CLEAR  = 3'b100
    } state_t;

    // What the update cycle needs to remember of the accepted item.
    typedef struct packed {
        logic                 is_read;
        logic                 rgb;
        logic                 in_range;
        logic [WIDE_AW-1:0]   red_addr;
        logic [NARROW_AW-1:0] green_addr;
        logic [NARROW_AW-1:0] blue_addr;
        logic [BIN_NUM_W-1:0] bin_number;
    } item_t;

    state_t             state_reg;
    state_t             state_next;
    logic [WIDE_AW-1:0] clr_cnt_reg;
    logic [WIDE_AW-1:0] clr_cnt_next;
    logic [MODE_W-1:0]  mode_reg;
    item_t              item_reg;
    item_t              item_next;

    logic               accept;
    logic               is_rgb;
    logic               is_wide;
    logic [SAMPLE_W-1:0] sel_sample;
    logic [SAMPLE_W-1:0] red_sel;

    logic               red_we;
    logic               narrow_we;
    logic [WIDE_AW-1:0]   red_waddr;
    logic [NARROW_AW-1:0] green_waddr;
    logic [NARROW_AW-1:0] blue_waddr;
    logic [COUNT_W-1:0] red_wdata;
    logic [COUNT_W-1:0] green_wdata;
    logic [COUNT_W-1:0] blue_wdata;
    logic [COUNT_W-1:0] red_rdata;
    logic [COUNT_W-1:0] green_rdata;
    logic [COUNT_W-1:0] blue_rdata;

    merge_ctrl_t        merge_ctrl;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] bumped;
        bumped = (count == COUNT_MAX) ? count : count + 1'b1;
        return bumped;
    endfunction

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign is_rgb  = mode_reg[MODE_RGB_BIT];
    assign is_wide = (mode_reg == MODE_GREY16);

    // Work out the bin of every lane straight from the command. The same
    // addresses drive the read ports, so the counts arrive in the update cycle.
    always_comb
    begin
        item_next.is_read = (cmd.kind == KIND_READ);
        sel_sample = item_next.is_read ? cmd.bin_index : cmd.gray;

        if (is_rgb)
        begin
            red_sel = item_next.is_read ? {8'd0, cmd.bin_index[7:0]} : {8'd0, cmd.red};
        end
        else if (is_wide)
        begin
            red_sel = sel_sample;
        end
        else
        begin
            red_sel = {8'd0, sel_sample[7:0]};
        end

        item_next.rgb        = is_rgb;
        item_next.in_range   = !is_wide || (32'(sel_sample) < WIDE_BINS);
        item_next.red_addr   = WIDE_AW'(red_sel);
        item_next.green_addr = item_next.is_read ? NARROW_AW'(cmd.bin_index[7:0])
                                                 : NARROW_AW'(cmd.green);
        item_next.blue_addr  = item_next.is_read ? NARROW_AW'(cmd.bin_index[7:0])
                                                 : NARROW_AW'(cmd.blue);
        item_next.bin_number = BIN_NUM_W'(red_sel);
    end

    // Sequencer: idle, the update cycle of one accumulate or read item, or the clearing sweep.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.kind == KIND_ACCUM || cmd.kind == KIND_READ)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (cmd.kind == KIND_CLEAR)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == WIDE_AW'(WIDE_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            mode_reg    <= MODE_GREY8;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    // Write ports: the sweep writes zero everywhere; an accumulate bumps the
    // grey or red lane, and in colour mode the green and blue lanes as well.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            red_we      = 1'b1;
            narrow_we   = 1'b1;
            red_waddr   = clr_cnt_reg;
            green_waddr = NARROW_AW'(clr_cnt_reg);
            blue_waddr  = NARROW_AW'(clr_cnt_reg);
            red_wdata   = '0;
            green_wdata = '0;
            blue_wdata  = '0;
        end
        else
        begin
            red_we      = (state_reg == ST_UPDATE) && !item_reg.is_read && item_reg.in_range;
            narrow_we   = (state_reg == ST_UPDATE) && !item_reg.is_read && item_reg.rgb;
            red_waddr   = item_reg.red_addr;
            green_waddr = item_reg.green_addr;
            blue_waddr  = item_reg.blue_addr;
            red_wdata   = sat_inc(red_rdata);
            green_wdata = sat_inc(green_rdata);
            blue_wdata  = sat_inc(blue_rdata);
        end
    end

    ihra_ram #(
        .DEPTH (WIDE_BINS),
        .WIDTH (COUNT_W)
    ) u_red_lane (
        .clk   (clk),
        .we    (red_we),
        .waddr (red_waddr),
        .wdata (red_wdata),
        .raddr (item_next.red_addr),
        .rdata (red_rdata)
    );

    ihra_ram #(
        .DEPTH (NARROW_BINS),
        .WIDTH (COUNT_W)
    ) u_green_lane (
        .clk   (clk),
        .we    (narrow_we),
        .waddr (green_waddr),
        .wdata (green_wdata),
        .raddr (item_next.green_addr),
        .rdata (green_rdata)
    );

    ihra_ram #(
        .DEPTH (NARROW_BINS),
        .WIDTH (COUNT_W)
    ) u_blue_lane (
        .clk   (clk),
        .we    (narrow_we),
        .waddr (blue_waddr),
        .wdata (blue_wdata),
        .raddr (item_next.blue_addr),
        .rdata (blue_rdata)
    );

    // A read hands the three lane counts to the merging stage in its update cycle.
    assign merge_ctrl.valid      = (state_reg == ST_UPDATE) && item_reg.is_read;
    assign merge_ctrl.rgb        = item_reg.rgb;
    assign merge_ctrl.in_range   = item_reg.in_range;
    assign merge_ctrl.bin_number = item_reg.bin_number;

    ihra_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (merge_ctrl),
        .red_count   (red_rdata),
        .green_count (green_rdata),
        .blue_count  (blue_rdata),
        .done        (done),
        .result      (result)
    );

    // The update cycle always follows an accepted item directly.
    a_update_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $past(start && !busy))
        else $error("update cycle without an accepted item");

    // A clear item starts the sweep from the first address.
    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == KIND_CLEAR) |=>
            (state_reg == ST_CLEAR && clr_cnt_reg == '0))
        else $error("clear item did not start the sweep at zero");

    // Every result comes from the update cycle of a read, through the merge stage's sum and result registers.
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE && item_reg.is_read, 2))
        else $error("result without a read item");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the image histogram block.
//
// A behavioural copy of the three count tables is kept here and updated as each
// item is accepted. Every read item pushes the bin number and count that the
// block should return onto a queue. A separate process compares each done
// strobe against the oldest entry on that queue. The named test tasks below are
// called in turn. They cover grey 8-bit, grey 16-bit and colour counting,
// clearing, the spare kind and mode codes, and a long random run.
module tb_top;
    import ihra_pkg::*;

    // Codes that the package does not name.
    localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RGB     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RGB_ALT = 2'd3;

    // The longest legitimate quiet spell is the clearing sweep over all WIDE_BINS
    // addresses. The watchdog allows several times that.
    localparam int QUIET_LIMIT = 4 * WIDE_BINS;

    // Cycles to let pass after the last item before the block counts as idle.
    localparam int SETTLE_CYCLES = 4;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    cmd_t              cmd = '0;
    logic              busy;
    logic              done;
    result_t           result;
    logic              mode_we = 1'b0;
    logic [MODE_W-1:0] mode_wdata = '0;

    // Our own copy of the tables and the mode register.
    bit [COUNT_W-1:0] hist_wide  [WIDE_BINS];
    bit [COUNT_W-1:0] hist_green [NARROW_BINS];
    bit [COUNT_W-1:0] hist_blue  [NARROW_BINS];
    logic [MODE_W-1:0] model_mode = MODE_GREY8;

    // Results that read items have yet to produce, oldest first.
    result_t pending_reads [$];

    int errors = 0;
    int idle_pct = 8;
    int quiet_cycles = 0;

    // Sample values reused within a random phase, so that reads hit bins that
    // have actually been counted.
    bit [15:0] sample_pool [8];

    image_histogram_rgb_average u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // A count that has reached its maximum is held there.
    function automatic bit [COUNT_W-1:0] bumped(bit [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Apply one accepted item to the table copy. A read item also pushes
    // its expected result.
    task automatic track_item(cmd_t c);
        result_t      want;
        bit [7:0]     nb;
        bit [SUM_W-1:0] sum;
        bit           rgb;
        rgb = model_mode[MODE_RGB_BIT];
        case (c.kind)
            KIND_ACCUM:
            begin
                if (rgb)
                begin
                    hist_wide[c.red]    = bumped(hist_wide[c.red]);
                    hist_green[c.green] = bumped(hist_green[c.green]);
                    hist_blue[c.blue]   = bumped(hist_blue[c.blue]);
                end
                else if (model_mode == MODE_GREY16)
                begin
                    if (int'(c.gray) < WIDE_BINS)
                        hist_wide[c.gray] = bumped(hist_wide[c.gray]);
                end
                else
                begin
                    hist_wide[c.gray[7:0]] = bumped(hist_wide[c.gray[7:0]]);
                end
            end
            KIND_READ:
            begin
                if (rgb)
                begin
                    // The colour read averages the three channel counts of
                    // one bin. The division truncates.
                    nb  = c.bin_index[7:0];
                    sum = SUM_W'(hist_wide[nb]) + SUM_W'(hist_green[nb])
                        + SUM_W'(hist_blue[nb]);
                    want.bin_number = BIN_NUM_W'(nb);
                    want.bin_count  = BIN_COUNT_W'(sum / 3);
                end
                else if (model_mode == MODE_GREY16)
                begin
                    want.bin_number = c.bin_index;
                    want.bin_count  = (int'(c.bin_index) < WIDE_BINS)
                                    ? hist_wide[c.bin_index] : '0;
                end
                else
                begin
                    want.bin_number = BIN_NUM_W'(c.bin_index[7:0]);
                    want.bin_count  = hist_wide[c.bin_index[7:0]];
                end
                pending_reads.push_back(want);
            end
            KIND_CLEAR:
            begin
                foreach (hist_wide[i])
                    hist_wide[i] = '0;
                foreach (hist_green[i])
                begin
                    hist_green[i] = '0;
                    hist_blue[i]  = '0;
                end
            end
            default:
            begin
                // The spare kind is ignored by the block.
            end
        endcase
    endtask

    // Offer one item, with a random idle gap first, and hold it until it is
    // accepted. Called and returning on a rising edge. Start is left high so
    // that back-to-back items never lower and raise it in the same step.
    task automatic send_item(logic [KIND_W-1:0] kind, logic [15:0] gray,
                             logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic [15:0] bin_index);
        cmd_t c;
        c.kind      = kind;
        c.gray      = gray;
        c.red       = red;
        c.green     = green;
        c.blue      = blue;
        c.bin_index = bin_index;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        // Inputs and busy only change on rising edges, so the falling edge is
        // a safe place to see whether the next edge accepts the item.
        do
            @(negedge clk);
        while (busy);
        track_item(c);
        @(posedge clk);
    endtask

    // Stop sending and wait until every read has returned, the last item has
    // had time to finish and any clearing sweep is over.
    task automatic settle();
        start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // Write the mode register. Only ever called straight after settle.
    task automatic write_mode(logic [MODE_W-1:0] m);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        model_mode = m;
        mode_we    <= 1'b0;
    endtask

    // Grey 8-bit mode: only the low byte of the sample and of the bin index
    // counts, so the upper bits are set to show that they are dropped.
    task automatic test_grey8();
        settle();
        write_mode(MODE_GREY8);
        send_item(KIND_ACCUM, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_ACCUM, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(KIND_ACCUM, 16'hAB12, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_ACCUM, 16'h0012, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'hFF12);
        send_item(KIND_READ,  16'hFFFF, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    endtask

    // Grey 16-bit mode on the same table, which is not cleared by the mode
    // change, so bins counted in 8-bit mode still show.
    task automatic test_grey16();
        settle();
        write_mode(MODE_GREY16);
        send_item(KIND_ACCUM, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_ACCUM, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_ACCUM, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h00FF);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h0012);
    endtask

    // Colour mode, where red shares the grey table and a read averages the
    // three channels.
    task automatic test_rgb();
        settle();
        write_mode(MODE_RGB);
        send_item(KIND_ACCUM, 16'h0000, 8'hFF, 8'h00, 8'h01, 16'h0000);
        send_item(KIND_ACCUM, 16'hFFFF, 8'h01, 8'h01, 8'hFF, 16'h0000);
        send_item(KIND_ACCUM, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'hAAFF);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h0001);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h5500);
    endtask

    // Mode code 3 must act as colour mode. The spare kind must give no result.
    // A clear must zero every table.
    task automatic test_clear_and_spare();
        settle();
        write_mode(MODE_RGB_ALT);
        send_item(KIND_SPARE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(KIND_ACCUM, 16'h0000, 8'h12, 8'h12, 8'h12, 16'h0000);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h0012);
        send_item(KIND_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h0012);
        send_item(KIND_READ,  16'h0000, 8'h00, 8'h00, 8'h00, 16'h00FF);
    endtask

    // Random phases through every mode. Most items are pixels and reads drawn
    // from a small pool of values, so that counts build up and reads find them.
    // The rest are fully random values and spare kinds. Two phases clear the
    // tables part way through. The first phase runs with no idle gaps at all.
    task automatic test_random();
        logic [MODE_W-1:0] phase_mode [7] = '{MODE_GREY8, MODE_GREY16, MODE_RGB,
                                              MODE_RGB_ALT, MODE_GREY8, MODE_RGB,
                                              MODE_GREY16};
        int                r;
        logic [KIND_W-1:0] kind;
        logic [15:0]       gray;
        logic [15:0]       bin_index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        for (int p = 0; p < 7; p++)
        begin
            settle();
            write_mode(phase_mode[p]);
            idle_pct = (p == 0) ? 0 : 8;
            foreach (sample_pool[i])
                sample_pool[i] = 16'($urandom);
            for (int n = 0; n < 64; n++)
            begin
                r = $urandom_range(99);
                if ((p == 2 || p == 5) && n == 32)
                    kind = KIND_CLEAR;
                else if (r < 55)
                    kind = KIND_ACCUM;
                else if (r < 95)
                    kind = KIND_READ;
                else
                    kind = KIND_SPARE;
                gray  = ($urandom_range(1) != 0) ? sample_pool[$urandom_range(7)]
                                                 : 16'($urandom);
                red   = ($urandom_range(1) != 0) ? sample_pool[$urandom_range(7)][7:0]
                                                 : 8'($urandom);
                green = ($urandom_range(1) != 0) ? sample_pool[$urandom_range(7)][7:0]
                                                 : 8'($urandom);
                blue  = ($urandom_range(1) != 0) ? sample_pool[$urandom_range(7)][7:0]
                                                 : 8'($urandom);
                r = $urandom_range(9);
                if (r < 4)
                    bin_index = sample_pool[$urandom_range(7)];
                else if (r < 8)
                    bin_index = {8'($urandom), sample_pool[$urandom_range(7)][7:0]};
                else
                    bin_index = 16'($urandom);
                send_item(kind, gray, red, green, blue, bin_index);
            end
        end
    endtask

    // Each done strobe is taken on the falling edge after it rises, and checked
    // field by field against the oldest expected read.
    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected result: bin_number %0d bin_count %0d",
                         $time, result.bin_number, result.bin_count);
                errors++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (result.bin_number !== want.bin_number)
                begin
                    $display("%0t: bin_number mismatch: expected %0d, actual %0d",
                             $time, want.bin_number, result.bin_number);
                    errors++;
                end
                if (result.bin_count !== want.bin_count)
                begin
                    $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                             $time, want.bin_count, result.bin_count);
                    errors++;
                end
            end
        end
    end

    // The watchdog counts cycles in which neither an item is accepted nor a
    // result is delivered.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        // Reset is held low at the start. The block then sweeps its tables,
        // and the first item simply waits for busy to fall.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_grey8();
        test_grey16();
        test_rgb();
        test_clear_and_spare();
        test_random();
        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== image_histogram_rgb_average.f =====
rtl/core/ihra_pkg.sv
rtl/core/ihra_ram.sv
rtl/core/ihra_merge.sv
rtl/core/image_histogram_rgb_average.sv
tb/tb_top.sv
